// ===== rtl/dbam_pkg.sv =====
`default_nettype none
package dbam_pkg;

  localparam int DBAM_TRACK_COUNT  = 35;
  localparam int DBAM_SECTOR_BYTES = 256;
  localparam int MAP_FIRST         = 4;
  localparam int OFFSET_W          = 18;
  localparam int BLK_W             = 11;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_RSVD  = 2'd3
  } dbam_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } dbam_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch item fields, issue row read
    logic load_wr;     // write raw map byte
    logic out_direct;  // result without a lookup (load, error)
    logic out_mod;     // result from row data, update row
  } dbam_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lookup;      // query or mark with good geometry
  } dbam_stat_t;

  function automatic logic [4:0] zone_sectors(input logic [5:0] track);
    if (track <= 6'd17)      return 5'd21;
    else if (track <= 6'd24) return 5'd19;
    else if (track <= 6'd30) return 5'd18;
    else                     return 5'd17;
  endfunction

  // sectors on all tracks below this one (track >= 1)
  function automatic logic [BLK_W-1:0] blocks_before(input logic [5:0] track);
    logic [BLK_W-1:0] t;
    t = BLK_W'(track);
    if (track <= 6'd17)      return BLK_W'(21) * (t - BLK_W'(1));
    else if (track <= 6'd24) return BLK_W'(357) + BLK_W'(19) * (t - BLK_W'(18));
    else if (track <= 6'd30) return BLK_W'(490) + BLK_W'(18) * (t - BLK_W'(25));
    else                     return BLK_W'(598) + BLK_W'(17) * (t - BLK_W'(31));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/disk_block_allocation_map_unit.sv =====
`default_nettype none
// channel  handshake            fields
// in       in_valid/in_ready    in_cmd, in_track, in_sector, in_map_index, in_map_byte
// out      out_valid/out_ready  out_is_free, out_free_count, out_byte_offset, out_error
//
// Load and rejected items give their result directly; for query and mark the
// row read from the track memory is registered, then the row is updated.
// Reset clears per-byte valid flags at once, so there is no clearing pass.
// A new item is taken when no query or mark is being updated and the result
// register is empty or drains in the same cycle.
module disk_block_allocation_map_unit
  import dbam_pkg::*;
#(
  parameter int TRACK_COUNT  = DBAM_TRACK_COUNT,
  parameter int SECTOR_BYTES = DBAM_SECTOR_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_track,
  input  wire logic [4:0]  in_sector,
  input  wire logic [7:0]  in_map_index,
  input  wire logic [7:0]  in_map_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_free,
  output logic [7:0]       out_free_count,
  output logic [17:0]      out_byte_offset,
  output logic             out_error
);

  dbam_cmd_t  cmd;
  dbam_stat_t stat;

  dbam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dbam_dp #(
    .TRACK_COUNT  (TRACK_COUNT),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_track        (in_track),
    .in_sector       (in_sector),
    .in_map_index    (in_map_index),
    .in_map_byte     (in_map_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_is_free     (out_is_free),
    .out_free_count  (out_free_count),
    .out_byte_offset (out_byte_offset),
    .out_error       (out_error)
  );

endmodule
`default_nettype wire

// ===== rtl/dbam_ctrl.sv =====
`default_nettype none
module dbam_ctrl
  import dbam_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dbam_stat_t stat,
  output dbam_cmd_t       cmd
);

  dbam_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.lookup) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture    = accept;
        cmd.load_wr    = accept && !stat.lookup;
        cmd.out_direct = accept && !stat.lookup;
      end
      ST_MOD: begin
        cmd.out_mod = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_direct || cmd.out_mod) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dbam_dp.sv =====
`default_nettype none
module dbam_dp
  import dbam_pkg::*;
#(
  parameter int TRACK_COUNT  = DBAM_TRACK_COUNT,
  parameter int SECTOR_BYTES = DBAM_SECTOR_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_track,
  input  wire logic [4:0]  in_sector,
  input  wire logic [7:0]  in_map_index,
  input  wire logic [7:0]  in_map_byte,
  input  wire dbam_cmd_t   cmd,
  output dbam_stat_t       stat,
  output logic             out_is_free,
  output logic [7:0]       out_free_count,
  output logic [17:0]      out_byte_offset,
  output logic             out_error
);

  localparam int ROW_AW     = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int BYTE_AW    = ROW_AW + 2;
  localparam int STORE_DEPTH = 4 * TRACK_COUNT;
  localparam int SB_W       = $clog2(SECTOR_BYTES + 1);
  localparam int PROD_W     = BLK_W + SB_W;

  // one row per track: byte 0 free count, bytes 1..3 bitmap
  logic [31:0]            mem [TRACK_COUNT];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [31:0]            rd_data_r;

  logic [ROW_AW-1:0] row_r;
  logic [4:0]        sector_r;
  logic              mark_r;
  logic [BLK_W-1:0]  blocks_r;

  logic geom_ok, is_lookup, load_ok;
  logic [7:0] idx_off;
  logic [ROW_AW-1:0] rd_row;

  assign geom_ok   = (in_track != 6'd0) && (in_track <= 6'(TRACK_COUNT))
                     && (in_sector < zone_sectors(in_track));
  assign is_lookup = ((in_cmd == CMD_QUERY) || (in_cmd == CMD_MARK)) && geom_ok;
  assign stat.lookup = is_lookup;

  assign idx_off = in_map_index - 8'(MAP_FIRST);
  assign load_ok = (in_cmd == CMD_LOAD) && (in_map_index >= 8'(MAP_FIRST))
                   && (9'(in_map_index) < 9'(MAP_FIRST + STORE_DEPTH));
  assign rd_row  = ROW_AW'(in_track - 6'd1);

  // modify stage
  logic [7:0]  cnt_eff, bm_eff, cnt_new, bm_new;
  logic [1:0]  bsel;
  logic [2:0]  bit_pos;
  logic        was_free, do_clr;
  logic [BYTE_AW-1:0] cnt_vi, bm_vi;
  logic [PROD_W-1:0] prod;

  assign bsel    = sector_r[4:3] + 2'd1;
  assign bit_pos = sector_r[2:0];
  assign cnt_vi  = {row_r, 2'd0};
  assign bm_vi   = {row_r, bsel};

  always_comb begin
    cnt_eff = valid_r[cnt_vi] ? rd_data_r[7:0] : 8'd0;
    case (bsel)
      2'd1:    bm_eff = rd_data_r[15:8];
      2'd2:    bm_eff = rd_data_r[23:16];
      default: bm_eff = rd_data_r[31:24];
    endcase
    if (!valid_r[bm_vi]) bm_eff = 8'd0;
    was_free = bm_eff[bit_pos];
    do_clr   = mark_r && was_free;
    bm_new   = bm_eff & ~(8'd1 << bit_pos);
    cnt_new  = (cnt_eff != 8'd0) ? cnt_eff - 8'd1 : cnt_eff;
  end

  assign prod = PROD_W'(blocks_r) * PROD_W'(SECTOR_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[rd_row];
      row_r     <= rd_row;
      sector_r  <= in_sector;
      mark_r    <= (in_cmd == CMD_MARK);
      blocks_r  <= blocks_before(in_track) + BLK_W'(in_sector);
    end
    if (cmd.load_wr && load_ok) begin
      mem[idx_off[BYTE_AW-1:2]][idx_off[1:0]*8 +: 8] <= in_map_byte;
    end
    if (cmd.out_mod && do_clr) begin
      mem[row_r][7:0]        <= cnt_new;
      mem[row_r][bsel*8 +: 8] <= bm_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.load_wr && load_ok) valid_r[idx_off[BYTE_AW-1:0]] <= 1'b1;
      if (cmd.out_mod && do_clr) begin
        valid_r[cnt_vi] <= 1'b1;
        valid_r[bm_vi]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_direct) begin
      out_is_free     <= 1'b0;
      out_free_count  <= 8'd0;
      out_byte_offset <= 18'd0;
      out_error       <= (in_cmd != CMD_LOAD);
    end else if (cmd.out_mod) begin
      out_is_free     <= was_free;
      out_free_count  <= do_clr ? cnt_new : cnt_eff;
      out_byte_offset <= prod[OFFSET_W-1:0];
      out_error       <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/dbam_alloc_checker.sv =====
`timescale 1ns / 100ps
module dbam_alloc_checker
  import dbam_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [5:0]  in_track,
  input  wire logic [4:0]  in_sector,
  input  wire logic [7:0]  in_map_index,
  input  wire logic [7:0]  in_map_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_is_free,
  input  wire logic [7:0]  out_free_count,
  input  wire logic [17:0] out_byte_offset,
  input  wire logic        out_error,
  output int               fail_count,
  output int               pending,
  output int               results_checked
);

  typedef struct packed {
    logic        is_free;
    logic [7:0]  free_count;
    logic [17:0] byte_offset;
    logic        error;
  } alloc_result_t;

  localparam int MAP_BYTES = 4 * DBAM_TRACK_COUNT;

  // per track: free count, then three bitmap bytes
  logic [7:0]    alloc_map [MAP_BYTES];
  alloc_result_t expected_q [$];

  function automatic int sectors_on(input int track);
    if (track <= 17) return 21;
    if (track <= 24) return 19;
    if (track <= 30) return 18;
    return 17;
  endfunction

  // applies one item to the local map copy and returns the result it should give
  function automatic alloc_result_t apply_command(input dbam_op_t op, input logic [5:0] track,
                                                  input logic [4:0] sector,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] val);
    alloc_result_t res;
    int            row;
    int            pos;
    int            blocks;
    int            t;
    logic          was_free;
    res = '0;
    case (op)
      CMD_LOAD: begin
        if (idx >= MAP_FIRST && idx < MAP_FIRST + MAP_BYTES)
          alloc_map[idx - MAP_FIRST] = val;
      end
      CMD_RSVD: begin
        res.error = 1'b1;
      end
      default: begin
        if (track == 0 || track > DBAM_TRACK_COUNT || sector >= sectors_on(track)) begin
          res.error = 1'b1;
        end else begin
          row      = 4 * (int'(track) - 1);
          pos      = row + 1 + int'(sector[4:3]);
          was_free = alloc_map[pos][sector[2:0]];
          if (op == CMD_MARK && was_free) begin
            alloc_map[pos][sector[2:0]] = 1'b0;
            // count saturates at zero
            if (alloc_map[row] != 8'd0)
              alloc_map[row] = alloc_map[row] - 8'd1;
          end
          blocks = int'(sector);
          for (t = 1; t < track; t++)
            blocks += sectors_on(t);
          res.is_free     = was_free;
          res.free_count  = alloc_map[row];
          res.byte_offset = 18'(blocks * DBAM_SECTOR_BYTES);
        end
      end
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string what, input alloc_result_t exp_res,
                                       input alloc_result_t got_res);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected free=%0b count=%0d offset=%0d err=%0b,",
               $realtime, what,
               exp_res.is_free, exp_res.free_count, exp_res.byte_offset, exp_res.error);
      $display("    got free=%0b count=%0d offset=%0d err=%0b",
               got_res.is_free, got_res.free_count, got_res.byte_offset, got_res.error);
    end
  endfunction

  always @(posedge clk) begin
    alloc_result_t got_res;
    alloc_result_t exp_res;
    alloc_result_t pred_res;
    if (!rst_n) begin
      foreach (alloc_map[i]) alloc_map[i] = 8'd0;
      expected_q.delete();
    end else begin
      // result first: it always belongs to an item taken on an earlier edge
      if (out_valid && out_ready) begin
        got_res = {out_is_free, out_free_count, out_byte_offset, out_error};
        if (expected_q.size() == 0) begin
          note_failure("result with no item outstanding", '0, got_res);
        end else begin
          exp_res = expected_q.pop_front();
          results_checked++;
          if (got_res !== exp_res)
            note_failure("result mismatch", exp_res, got_res);
        end
      end
      if (in_valid && in_ready) begin
        pred_res = apply_command(dbam_op_t'(in_cmd), in_track, in_sector,
                                 in_map_index, in_map_byte);
        expected_q.insert(expected_q.size(), pred_res);
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_disk_block_allocation_map_unit.sv =====
`timescale 1ns / 100ps
module tb_disk_block_allocation_map_unit;
  import dbam_pkg::*;

  localparam int STALL_LIMIT      = 4000;
  localparam int RANDOM_PER_PHASE = 360;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [1:0]  in_cmd       = 2'd0;
  logic [5:0]  in_track     = 6'd0;
  logic [4:0]  in_sector    = 5'd0;
  logic [7:0]  in_map_index = 8'd0;
  logic [7:0]  in_map_byte  = 8'd0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_is_free;
  logic [7:0]  out_free_count;
  logic [17:0] out_byte_offset;
  logic        out_error;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int op_count [4];
  int fail_count;
  int pending;
  int results_checked;

  disk_block_allocation_map_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_track       (in_track),
    .in_sector      (in_sector),
    .in_map_index   (in_map_index),
    .in_map_byte    (in_map_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_free    (out_is_free),
    .out_free_count (out_free_count),
    .out_byte_offset(out_byte_offset),
    .out_error      (out_error)
  );

  dbam_alloc_checker u_alloc_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_track       (in_track),
    .in_sector      (in_sector),
    .in_map_index   (in_map_index),
    .in_map_byte    (in_map_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_free    (out_is_free),
    .out_free_count (out_free_count),
    .out_byte_offset(out_byte_offset),
    .out_error      (out_error),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // nothing moving on either channel for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input dbam_op_t op, input logic [5:0] track,
                           input logic [4:0] sector, input logic [7:0] idx,
                           input logic [7:0] val);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid     <= 1'b1;
    in_cmd       <= op;
    in_track     <= track;
    in_sector    <= sector;
    in_map_index <= idx;
    in_map_byte  <= val;
    op_count[op]++;
    do @(posedge clk); while (!in_ready);
  endtask

  // whole track entry: free count, then the three bitmap bytes
  task automatic load_track_row(input int track);
    int         base;
    int         b;
    logic [7:0] cnt;
    base = MAP_FIRST + 4 * (track - 1);
    cnt  = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
    send_item(CMD_LOAD, 6'($urandom), 5'($urandom), 8'(base), cnt);
    for (b = 1; b < 4; b++)
      send_item(CMD_LOAD, 6'($urandom), 5'($urandom), 8'(base + b), 8'($urandom));
  endtask

  task automatic send_random_item();
    dbam_op_t   op;
    int         pick;
    logic [5:0] track;
    logic [4:0] sector;
    logic [7:0] idx;
    pick = $urandom_range(99);
    if (pick < 15)      op = CMD_LOAD;
    else if (pick < 50) op = CMD_QUERY;
    else if (pick < 92) op = CMD_MARK;
    else                op = CMD_RSVD;
    if ($urandom_range(99) < 85) begin
      track  = 6'($urandom_range(DBAM_TRACK_COUNT, 1));
      sector = 5'($urandom_range(int'(zone_sectors(track)) - 1));
    end else begin
      track  = 6'($urandom);
      sector = 5'($urandom);
    end
    if ($urandom_range(99) < 85)
      idx = 8'($urandom_range(MAP_FIRST + 4 * DBAM_TRACK_COUNT - 1, MAP_FIRST));
    else
      idx = 8'($urandom);
    send_item(op, track, sector, idx, 8'($urandom));
  endtask

  task automatic run_random(input int n_items);
    int done;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 12) begin
        load_track_row($urandom_range(DBAM_TRACK_COUNT, 1));
        done += 4;
      end else begin
        send_random_item();
        done++;
      end
    end
  endtask

  initial begin
    send_gap_pct   = 26;
    recv_stall_pct = 68;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // track 1 fully free with count 5; last map byte frees sector 16 of track 35
    send_item(CMD_LOAD, 6'd0, 5'd0, 8'd4, 8'd5);
    send_item(CMD_LOAD, 6'd0, 5'd0, 8'd5, 8'hFF);
    send_item(CMD_LOAD, 6'd0, 5'd0, 8'd6, 8'hFF);
    send_item(CMD_LOAD, 6'd0, 5'd0, 8'd7, 8'h1F);
    send_item(CMD_LOAD, 6'd0, 5'd0, 8'd143, 8'h01);
    // indexes outside the kept range
    send_item(CMD_LOAD, 6'd1, 5'd0, 8'd3, 8'hAA);
    send_item(CMD_LOAD, 6'd1, 5'd0, 8'd144, 8'h55);
    send_item(CMD_LOAD, 6'd63, 5'd31, 8'd255, 8'hFF);
    send_item(CMD_QUERY, 6'd1, 5'd0, 8'd0, 8'd0);
    send_item(CMD_MARK, 6'd1, 5'd0, 8'd0, 8'd0);
    send_item(CMD_MARK, 6'd1, 5'd0, 8'd0, 8'd0);    // already used
    send_item(CMD_QUERY, 6'd1, 5'd20, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd1, 5'd21, 8'd0, 8'd0);  // past zone end
    send_item(CMD_QUERY, 6'd0, 5'd0, 8'd0, 8'd0);
    send_item(CMD_MARK, 6'd36, 5'd0, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd63, 5'd31, 8'd0, 8'd0);
    send_item(CMD_RSVD, 6'd1, 5'd0, 8'd0, 8'd0);
    send_item(CMD_MARK, 6'd35, 5'd16, 8'd0, 8'd0);  // free bit, count already zero
    send_item(CMD_QUERY, 6'd35, 5'd17, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd18, 5'd18, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd18, 5'd19, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd24, 5'd18, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd25, 5'd17, 8'd0, 8'd0);
    send_item(CMD_MARK, 6'd30, 5'd17, 8'd0, 8'd0);
    send_item(CMD_QUERY, 6'd31, 5'd16, 8'd0, 8'd0);

    run_random(RANDOM_PER_PHASE);
    send_gap_pct   = 68;
    recv_stall_pct = 26;
    run_random(RANDOM_PER_PHASE);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("items sent: %0d loads, %0d queries, %0d marks, %0d reserved; %0d results checked",
             op_count[CMD_LOAD], op_count[CMD_QUERY], op_count[CMD_MARK], op_count[CMD_RSVD],
             results_checked);
    $display("random phases ran with sender gaps 26/68/0 and receiver stalls 68/26/0 percent");
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
